// ===== rtl/core/prs_pkg.sv =====
// Shared types and constants for the priority ready and sleep scheduler.
`timescale 1ns / 1ps
`default_nettype none
package prs_pkg;
	localparam int QueueDepth  = 16;
	localparam int IdBits      = 8;
	localparam int PrioBits    = 6;
	localparam int TickBits    = 32;
	localparam logic [PrioBits-1:0] MaxPriority = 6'd63;
	localparam logic [7:0] SliceAtReset = 8'd4;

	localparam logic [2:0] FUNC_MAKE_READY = 3'd0;
	localparam logic [2:0] FUNC_SLEEP      = 3'd1;
	localparam logic [2:0] FUNC_YIELD      = 3'd2;
	localparam logic [2:0] FUNC_BLOCK      = 3'd3;
	localparam logic [2:0] FUNC_TICK       = 3'd4;
	localparam logic [2:0] FUNC_SET_PRIO   = 3'd5;

	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_READY_FULL  = 2'd1;
	localparam logic [1:0] STATUS_SLEEP_FULL  = 2'd2;

	typedef struct packed {
		logic [IdBits-1:0]   id;
		logic [PrioBits-1:0] prio;
	} rdy_entry_t;

	typedef struct packed {
		logic [TickBits-1:0] wake;
		logic [IdBits-1:0]   id;
		logic [PrioBits-1:0] prio;
	} slp_entry_t;

	// Command broadcast to a queue's row of cells.
	typedef struct packed {
		logic       insert;
		logic       pop;
	} q_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/prs_ready_cell.sv =====
// One slot of the priority-sorted ready queue.
`timescale 1ns / 1ps
`default_nettype none
module prs_ready_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  prs_pkg::q_cmd_t      cmd,
	input  prs_pkg::rdy_entry_t  new_entry,
	input  wire                  prev_valid,
	input  prs_pkg::rdy_entry_t  prev_entry,
	input  wire                  prev_goes_after,
	input  wire                  next_valid,
	input  prs_pkg::rdy_entry_t  next_entry,
	output logic                 valid,
	output prs_pkg::rdy_entry_t  entry,
	output logic                 goes_after
);
	import prs_pkg::*;
	logic        valid_q;
	rdy_entry_t  entry_q;
	logic        here_after;

	// New entry lands behind every entry of equal or higher priority.
	assign here_after = valid_q && (entry_q.prio >= new_entry.prio);
	assign goes_after = here_after;
	assign valid = valid_q;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= next_valid;
		end else if (cmd.insert) begin
			valid_q <= valid_q || prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			entry_q <= next_entry;
		end else if (cmd.insert && !here_after) begin
			if (prev_goes_after) begin
				entry_q <= new_entry;
			end else if (prev_valid) begin
				entry_q <= prev_entry;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/prs_sleep_cell.sv =====
// One slot of the wake-ordered sleep queue.
`timescale 1ns / 1ps
`default_nettype none
module prs_sleep_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  prs_pkg::q_cmd_t      cmd,
	input  prs_pkg::slp_entry_t  new_entry,
	input  wire                  prev_valid,
	input  prs_pkg::slp_entry_t  prev_entry,
	input  wire                  prev_goes_after,
	input  wire                  next_valid,
	input  prs_pkg::slp_entry_t  next_entry,
	output logic                 valid,
	output prs_pkg::slp_entry_t  entry,
	output logic                 goes_after
);
	import prs_pkg::*;
	logic        valid_q;
	slp_entry_t  entry_q;
	logic        here_after;

	assign here_after = valid_q && (entry_q.wake <= new_entry.wake);
	assign goes_after = here_after;
	assign valid = valid_q;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= next_valid;
		end else if (cmd.insert) begin
			valid_q <= valid_q || prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			entry_q <= next_entry;
		end else if (cmd.insert && !here_after) begin
			if (prev_goes_after) begin
				entry_q <= new_entry;
			end else if (prev_valid) begin
				entry_q <= prev_entry;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/priority_ready_and_sleep_scheduler_top.sv =====
// Top level of the priority ready and sleep scheduler.
// make_ready, sleep_until and block go from decode to the result register; yield and
// set_priority first put the old runner back in the queue when it gives up the processor;
// tick moves due sleepers to the ready queue, then updates slice count and preempt request.
// One transaction at a time: the next request is accepted in the cycle after the result
// register loads.
// Reset: both queues empty, idle runs, slice count 0, time slice 4, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module priority_ready_and_sleep_scheduler_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         time_slice_we,
	input  wire  [7:0]  time_slice_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	// tdata: func[2:0], task_id[10:3], task_priority[16:11], tick_value[48:17], zero pad
	input  wire  [55:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// tdata: running_id[7:0], running_priority[13:8], running_idle[14], switched[15],
	// preempt_request[16], woke_count[21:17], status[23:22]
	output logic [23:0] m_tdata
);
	import prs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECODE, ST_READY_INS, ST_WAKE, ST_TICK_END, ST_DONE
	} state_t;

	state_t state_q;
	logic [2:0]           func_q;
	logic [IdBits-1:0]    tid_q;
	logic [PrioBits-1:0]  tprio_q;
	logic [TickBits-1:0]  tick_q;
	logic [7:0]           time_slice_q;
	logic [IdBits-1:0]    cur_id_q;
	logic [PrioBits-1:0]  cur_prio_q;
	logic                 cur_idle_q;
	logic [7:0]           slice_q;
	logic                 switched_q;
	logic                 preempt_q;
	logic [4:0]           woke_q;
	logic [1:0]           status_q;
	logic                 out_valid_q;
	logic [23:0]          out_data_q;

	// Cell rows. Index 0 is the queue front.
	q_cmd_t      r_cmd, s_cmd;
	rdy_entry_t  r_new;
	slp_entry_t  s_new;
	logic        r_valid [QueueDepth];
	rdy_entry_t  r_entry [QueueDepth];
	logic        r_after [QueueDepth];
	logic        s_valid [QueueDepth];
	slp_entry_t  s_entry [QueueDepth];
	logic        s_after [QueueDepth];

	genvar g;
	generate
		for (g = 0; g < QueueDepth; g++) begin : g_cells
			logic        rpv, rpa, rnv, spv, spa, snv;
			rdy_entry_t  rpe, rne;
			slp_entry_t  spe, sne;
			if (g == 0) begin : g_first
				assign rpv = 1'b1;
				assign rpa = 1'b1;
				assign rpe = r_new;
				assign spv = 1'b1;
				assign spa = 1'b1;
				assign spe = s_new;
			end else begin : g_mid
				assign rpv = r_valid[g-1];
				assign rpa = r_after[g-1];
				assign rpe = r_entry[g-1];
				assign spv = s_valid[g-1];
				assign spa = s_after[g-1];
				assign spe = s_entry[g-1];
			end
			if (g == QueueDepth - 1) begin : g_last
				assign rnv = 1'b0;
				assign rne = r_new;
				assign snv = 1'b0;
				assign sne = s_new;
			end else begin : g_inner
				assign rnv = r_valid[g+1];
				assign rne = r_entry[g+1];
				assign snv = s_valid[g+1];
				assign sne = s_entry[g+1];
			end
			prs_ready_cell u_rcell (
				.clk(clk), .arst_n(arst_n), .cmd(r_cmd), .new_entry(r_new),
				.prev_valid(rpv), .prev_entry(rpe), .prev_goes_after(rpa),
				.next_valid(rnv), .next_entry(rne),
				.valid(r_valid[g]), .entry(r_entry[g]), .goes_after(r_after[g])
			);
			prs_sleep_cell u_scell (
				.clk(clk), .arst_n(arst_n), .cmd(s_cmd), .new_entry(s_new),
				.prev_valid(spv), .prev_entry(spe), .prev_goes_after(spa),
				.next_valid(snv), .next_entry(sne),
				.valid(s_valid[g]), .entry(s_entry[g]), .goes_after(s_after[g])
			);
		end
	endgenerate

	// A queue is full when its last cell holds an entry; empty when its front is free.
	logic r_full, r_empty, s_full, s_empty;
	assign r_full  = r_valid[QueueDepth-1];
	assign r_empty = !r_valid[0];
	assign s_full  = s_valid[QueueDepth-1];
	assign s_empty = !s_valid[0];

	// Decide this cycle's queue commands and the entry offered to each row.
	logic front_wins, do_switch_pop, wake_due;
	assign front_wins = !r_empty && (r_entry[0].prio >= cur_prio_q);
	assign wake_due   = !s_empty && (s_entry[0].wake <= tick_q);

	// Yield or priority drop that pops the front must put the old runner back.
	logic needs_reinsert;
	assign needs_reinsert = do_switch_pop && !cur_idle_q &&
		(func_q == FUNC_YIELD || func_q == FUNC_SET_PRIO);

	// Load the result register once the previous result has been taken.
	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	always_comb begin
		r_cmd = '0;
		s_cmd = '0;
		r_new.id   = tid_q;
		r_new.prio = tprio_q;
		s_new.wake = tick_q;
		s_new.id   = cur_id_q;
		s_new.prio = cur_prio_q;
		do_switch_pop = 1'b0;
		unique case (state_q)
			ST_DECODE: begin
				unique case (func_q)
					FUNC_MAKE_READY: r_cmd.insert = !r_full;
					FUNC_SLEEP: begin
						// Queue the runner and pop the front in the same cycle.
						s_cmd.insert = !cur_idle_q && !s_full;
						do_switch_pop = (cur_idle_q || !s_full) && !r_empty;
					end
					FUNC_BLOCK: do_switch_pop = !r_empty;
					FUNC_YIELD: do_switch_pop = !r_empty && (cur_idle_q || front_wins);
					FUNC_SET_PRIO:
						do_switch_pop = !cur_idle_q && !r_empty && (r_entry[0].prio > tprio_q);
					default: ;
				endcase
				r_cmd.pop = do_switch_pop;
			end
			ST_READY_INS: begin
				// Reinsert the task that gave up the processor.
				r_new.id   = tid_q;
				r_new.prio = tprio_q;
				r_cmd.insert = 1'b1;
			end
			ST_WAKE: begin
				r_new.id   = s_entry[0].id;
				r_new.prio = s_entry[0].prio;
				r_cmd.insert = wake_due && !r_full;
				s_cmd.pop    = wake_due && !r_full;
			end
			default: ;
		endcase
	end

	logic [7:0] slice_next;
	assign slice_next = (slice_q == 8'hFF) ? slice_q : slice_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			time_slice_q <= SliceAtReset;
			cur_id_q     <= '0;
			cur_prio_q   <= '0;
			cur_idle_q   <= 1'b1;
			slice_q      <= '0;
			switched_q   <= 1'b0;
			preempt_q    <= 1'b0;
			woke_q       <= '0;
			status_q     <= STATUS_OK;
			out_valid_q  <= 1'b0;
		end else begin
			if (time_slice_we) begin
				time_slice_q <= time_slice_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						state_q    <= ST_DECODE;
						switched_q <= 1'b0;
						preempt_q  <= 1'b0;
						woke_q     <= '0;
						status_q   <= STATUS_OK;
					end
				end
				ST_DECODE: begin
					if (func_q == FUNC_TICK) begin
						state_q <= ST_WAKE;
					end else if (needs_reinsert) begin
						state_q <= ST_READY_INS;
					end else begin
						state_q <= ST_DONE;
					end
					unique case (func_q)
						FUNC_MAKE_READY: if (r_full) status_q <= STATUS_READY_FULL;
						FUNC_SLEEP, FUNC_BLOCK: begin
							if (func_q == FUNC_SLEEP && !cur_idle_q && s_full) begin
								status_q <= STATUS_SLEEP_FULL;
							end else begin
								slice_q <= '0;
								if (!r_empty) begin
									cur_id_q   <= r_entry[0].id;
									cur_prio_q <= r_entry[0].prio;
									cur_idle_q <= 1'b0;
									switched_q <= 1'b1;
								end else begin
									switched_q <= !cur_idle_q;
									cur_idle_q <= 1'b1;
									cur_id_q   <= '0;
									cur_prio_q <= '0;
								end
							end
						end
						FUNC_YIELD, FUNC_SET_PRIO: begin
							if (do_switch_pop) begin
								slice_q    <= '0;
								cur_id_q   <= r_entry[0].id;
								cur_prio_q <= r_entry[0].prio;
								cur_idle_q <= 1'b0;
								switched_q <= 1'b1;
							end else begin
								if (func_q == FUNC_SET_PRIO && !cur_idle_q) begin
									cur_prio_q <= tprio_q;
								end
								if (func_q == FUNC_YIELD) begin
									slice_q <= '0;
								end
							end
						end
						default: ;
					endcase
				end
				ST_READY_INS: state_q <= ST_DONE;
				ST_WAKE: begin
					if (wake_due && !r_full) begin
						if (woke_q != 5'd31) woke_q <= woke_q + 5'd1;
					end else begin
						if (wake_due) status_q <= STATUS_READY_FULL;
						state_q <= ST_TICK_END;
						slice_q <= slice_next;
					end
				end
				ST_TICK_END: begin
					state_q <= ST_DONE;
					if (cur_idle_q) begin
						preempt_q <= !r_empty;
					end else begin
						preempt_q <= (slice_q >= time_slice_q) ||
							(!r_empty && r_entry[0].prio > cur_prio_q);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the request; saturate priority and mask the id.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid && s_tready) begin
			func_q  <= s_tdata[2:0];
			tid_q   <= s_tdata[10:3];
			tprio_q <= (s_tdata[16:11] > MaxPriority) ? MaxPriority : s_tdata[16:11];
			tick_q  <= s_tdata[48:17];
		end else if (state_q == ST_DECODE && do_switch_pop) begin
			// Hold the old runner for reinsertion.
			tid_q   <= cur_id_q;
			tprio_q <= (func_q == FUNC_SET_PRIO) ? tprio_q : cur_prio_q;
		end
		if (out_load) begin
			out_data_q <= {status_q, woke_q, preempt_q, switched_q, cur_idle_q,
				cur_prio_q, cur_id_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
endmodule
`default_nettype wire

// ===== rtl/core/prs_checker.sv =====
// Port-level checks for the scheduler top level.
`timescale 1ns / 1ps
`default_nettype none
module prs_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");
	a_no_accept_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken during work");
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> m_tdata[13:0] == 14'd0)
		else $error("idle result carries task fields");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:22] != 2'd3)
		else $error("bad status");
endmodule
bind priority_ready_and_sleep_scheduler_top prs_checker u_prs_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
